/* hdl/sca_pkg.sv */
// Package for the still capture accumulator.
// Holds field widths, reset values, status and register codes, and the
// command/status structs shared by the controller and the datapath.
`timescale 1ns / 1ps

package sca_pkg;

    localparam int AXIS_N    = 3;
    localparam int AXIS_W    = 16;
    localparam int CNT_W     = 13;
    localparam int MDEV_W    = 11;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 13;
    localparam int MGK_W     = 10;
    localparam int DIFF_W    = AXIS_W + 1;
    localparam int SCALED_W  = DIFF_W + MGK_W;

    // divider retires one quotient bit per step; the mean fits 16 bits
    localparam int DIV_STEPS = AXIS_W;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    typedef logic signed [AXIS_W-1:0] t_axis;

    localparam logic [STAT_W-1:0] STAT_ACCUM    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_COMPLETE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_IGNORED  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXDEV = 1'b1;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic [CNT_W-1:0]  TARGET_RST = 13'd64;
    localparam logic [MDEV_W-1:0] MAXDEV_RST = 11'd50;
    localparam t_axis             MIN_RST    = 16'sh7FFF;
    localparam t_axis             MAX_RST    = 16'sh8000;
    localparam logic [MGK_W-1:0]  MG_PER_G   = 10'd1000;

    typedef struct packed {
        logic take_clear;   // clear command accepted
        logic take_ignore;  // sample accepted while capture is done
        logic take_sample;  // sample accepted for accumulation
        logic check;        // evaluate motion against running means
        logic update;       // fold sample into sums, extremes, count
        logic div_init;     // load dividers from sums
        logic div_step;     // one quotient bit on all three axes
        logic div_last;     // final step, write means
        logic emit;         // load result register
    } t_dp_cmd;

    typedef struct packed {
        logic done;         // capture complete
        logic out_free;     // result register can take a new result
    } t_dp_stat;

endpackage

/* hdl/still_capture_accumulator_unit.sv */
// Top level of the still capture accumulator: controller plus datapath.
// Depends on sca_pkg, sca_ctrl and sca_dpath.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+---------------------------------
//   input    | in        | i_in_valid / o_in_stall    | i_command, i_accel_x/y/z
//   result   | out       | o_out_valid / i_out_stall  | o_status .. o_max_z
//   config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A sample transaction runs from accept to result through one motion
// check, one update, one divider load and 16 steps of the three restoring
// dividers (one quotient bit per cycle), then the hand-off; the next item
// is taken the cycle after. Clear commands and samples after a finished
// capture go from accept straight to the hand-off. Synchronous active-low
// reset returns the capture to empty and the registers to 64 samples and
// 50 mg. The result register lets a new item be accepted while the last
// result is stalled; the hand-off waits if that result is still there.
// Config writes are always ready.
`timescale 1ns / 1ps

module still_capture_accumulator_unit #(
    parameter int MAX_TARGET = 4096,
    parameter int ONE_G_RAW  = 16384
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_command,
    input  logic signed [sca_pkg::AXIS_W-1:0] i_accel_x,
    input  logic signed [sca_pkg::AXIS_W-1:0] i_accel_y,
    input  logic signed [sca_pkg::AXIS_W-1:0] i_accel_z,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sca_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sca_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [sca_pkg::STAT_W-1:0]        o_status,
    output logic                              o_restarted,
    output logic [sca_pkg::CNT_W-1:0]         o_sample_count,
    output logic signed [sca_pkg::AXIS_W-1:0] o_mean_x,
    output logic signed [sca_pkg::AXIS_W-1:0] o_mean_y,
    output logic signed [sca_pkg::AXIS_W-1:0] o_mean_z,
    output logic signed [sca_pkg::AXIS_W-1:0] o_min_x,
    output logic signed [sca_pkg::AXIS_W-1:0] o_min_y,
    output logic signed [sca_pkg::AXIS_W-1:0] o_min_z,
    output logic signed [sca_pkg::AXIS_W-1:0] o_max_x,
    output logic signed [sca_pkg::AXIS_W-1:0] o_max_y,
    output logic signed [sca_pkg::AXIS_W-1:0] o_max_z
);

    sca_pkg::t_dp_cmd  w_cmd;
    sca_pkg::t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    sca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sca_dpath #(
        .MAX_TARGET (MAX_TARGET),
        .ONE_G_RAW  (ONE_G_RAW)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_accel_x      (i_accel_x),
        .i_accel_y      (i_accel_y),
        .i_accel_z      (i_accel_z),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_restarted    (o_restarted),
        .o_sample_count (o_sample_count),
        .o_mean_x       (o_mean_x),
        .o_mean_y       (o_mean_y),
        .o_mean_z       (o_mean_z),
        .o_min_x        (o_min_x),
        .o_min_y        (o_min_y),
        .o_min_z        (o_min_z),
        .o_max_x        (o_max_x),
        .o_max_y        (o_max_y),
        .o_max_z        (o_max_z)
    );

endmodule

/* hdl/sca_ctrl.sv */
// Controller for the still capture accumulator.
// Sequences accept, motion check, update, division and result hand-off.
// Depends on sca_pkg.
`timescale 1ns / 1ps

module sca_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_command,
    output logic              o_in_stall,
    input  sca_pkg::t_dp_stat i_stat,
    output sca_pkg::t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_UPDATE = 3'd2;
    localparam logic [2:0] S_DINIT  = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    logic [2:0]                  r_state, n_state;
    logic [sca_pkg::DIV_CW-1:0]  r_step, n_step;
    logic                        w_last;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_last     = (r_step == sca_pkg::DIV_CW'(sca_pkg::DIV_STEPS - 1));

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_command == sca_pkg::CMD_CLEAR) begin
                        o_cmd.take_clear = 1'b1;
                        n_state          = S_EMIT;
                    end else if (i_stat.done) begin
                        o_cmd.take_ignore = 1'b1;
                        n_state           = S_EMIT;
                    end else begin
                        o_cmd.take_sample = 1'b1;
                        n_state           = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_step         = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_last = w_last;
                n_step         = r_step + 1'b1;
                if (w_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

/* hdl/sca_dpath.sv */
// Datapath for the still capture accumulator: config registers, capture
// state, motion check, three restoring dividers and the result register.
// Depends on sca_pkg; driven by sca_ctrl commands.
`timescale 1ns / 1ps

module sca_dpath #(
    parameter int MAX_TARGET = 4096,
    parameter int ONE_G_RAW  = 16384
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sca_pkg::t_dp_cmd                  i_cmd,
    output sca_pkg::t_dp_stat                 o_stat,
    input  logic signed [sca_pkg::AXIS_W-1:0] i_accel_x,
    input  logic signed [sca_pkg::AXIS_W-1:0] i_accel_y,
    input  logic signed [sca_pkg::AXIS_W-1:0] i_accel_z,
    input  logic                              i_cfg_we,
    input  logic [sca_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sca_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [sca_pkg::STAT_W-1:0]        o_status,
    output logic                              o_restarted,
    output logic [sca_pkg::CNT_W-1:0]         o_sample_count,
    output logic signed [sca_pkg::AXIS_W-1:0] o_mean_x,
    output logic signed [sca_pkg::AXIS_W-1:0] o_mean_y,
    output logic signed [sca_pkg::AXIS_W-1:0] o_mean_z,
    output logic signed [sca_pkg::AXIS_W-1:0] o_min_x,
    output logic signed [sca_pkg::AXIS_W-1:0] o_min_y,
    output logic signed [sca_pkg::AXIS_W-1:0] o_min_z,
    output logic signed [sca_pkg::AXIS_W-1:0] o_max_x,
    output logic signed [sca_pkg::AXIS_W-1:0] o_max_y,
    output logic signed [sca_pkg::AXIS_W-1:0] o_max_z
);

    // count never exceeds the smaller of MAX_TARGET and the 13-bit target
    localparam int CNT_MAXV = (1 << sca_pkg::CNT_W) - 1;
    localparam int CNT_CAP  = (MAX_TARGET < CNT_MAXV) ? MAX_TARGET : CNT_MAXV;
    localparam int SUM_W    = $clog2(CNT_CAP) + sca_pkg::AXIS_W;
    localparam int LIM_W    = sca_pkg::MDEV_W + $clog2(ONE_G_RAW + 1);
    localparam int CMP_W    = (LIM_W > sca_pkg::SCALED_W) ? LIM_W : sca_pkg::SCALED_W;
    localparam int REM_W    = sca_pkg::CNT_W;

    localparam int AW = sca_pkg::AXIS_W;
    localparam int DW = sca_pkg::DIFF_W;
    localparam int SW = sca_pkg::SCALED_W;

    // config
    logic [sca_pkg::CNT_W-1:0]  r_target;
    logic [sca_pkg::MDEV_W-1:0] r_maxdev;
    logic [LIM_W-1:0]           r_lim;   // max_deviation_mg * ONE_G_RAW

    // capture state
    logic signed [SUM_W-1:0]   r_sum  [sca_pkg::AXIS_N];
    sca_pkg::t_axis            r_min  [sca_pkg::AXIS_N];
    sca_pkg::t_axis            r_max  [sca_pkg::AXIS_N];
    sca_pkg::t_axis            r_mean [sca_pkg::AXIS_N];
    logic [sca_pkg::CNT_W-1:0] r_cnt;
    logic                      r_done;

    // per-item working registers
    sca_pkg::t_axis            r_raw  [sca_pkg::AXIS_N];
    logic                      r_motion;
    logic [sca_pkg::STAT_W-1:0] r_status;
    logic                      r_restarted;

    // dividers
    logic                      r_neg  [sca_pkg::AXIS_N];
    logic [REM_W-1:0]          r_rem  [sca_pkg::AXIS_N];
    logic [AW-1:0]             r_dq   [sca_pkg::AXIS_N];

    // result register
    logic                       r_out_valid;
    logic [sca_pkg::STAT_W-1:0] r_o_status;
    logic                       r_o_restarted;
    logic [sca_pkg::CNT_W-1:0]  r_o_cnt;
    sca_pkg::t_axis             r_o_mean [sca_pkg::AXIS_N];
    sca_pkg::t_axis             r_o_min  [sca_pkg::AXIS_N];
    sca_pkg::t_axis             r_o_max  [sca_pkg::AXIS_N];

    sca_pkg::t_axis            w_in   [sca_pkg::AXIS_N];
    logic [DW-1:0]             w_diff [sca_pkg::AXIS_N];
    logic [DW-1:0]             w_abs  [sca_pkg::AXIS_N];
    logic [SW-1:0]             w_scl  [sca_pkg::AXIS_N];
    logic                      w_over [sca_pkg::AXIS_N];
    logic                      w_any_over;
    logic [SUM_W-1:0]          w_mag  [sca_pkg::AXIS_N];
    logic [REM_W:0]            w_trial[sca_pkg::AXIS_N];
    logic                      w_ge   [sca_pkg::AXIS_N];
    logic [REM_W-1:0]          n_rem  [sca_pkg::AXIS_N];
    logic [AW-1:0]             n_dq   [sca_pkg::AXIS_N];
    sca_pkg::t_axis            n_mean [sca_pkg::AXIS_N];
    logic [sca_pkg::CNT_W-1:0] n_cnt;
    logic                      n_done;
    logic                      w_out_free;
    logic [LIM_W-1:0]          w_lim;

    assign w_in[0] = i_accel_x;
    assign w_in[1] = i_accel_y;
    assign w_in[2] = i_accel_z;

    assign w_lim = LIM_W'(r_maxdev) * LIM_W'(ONE_G_RAW);

    // |raw - mean| > floor(P / 1000)  <=>  |raw - mean| * 1000 > P
    always_comb begin
        w_any_over = 1'b0;
        for (int i = 0; i < sca_pkg::AXIS_N; i++) begin
            w_diff[i] = {r_raw[i][AW-1], r_raw[i]} - {r_mean[i][AW-1], r_mean[i]};
            w_abs[i]  = w_diff[i][DW-1] ? (~w_diff[i] + 1'b1) : w_diff[i];
            w_scl[i]  = SW'(w_abs[i]) * SW'(sca_pkg::MG_PER_G);
            w_over[i] = CMP_W'(w_scl[i]) > CMP_W'(r_lim);
            w_any_over = w_any_over | w_over[i];
        end
    end

    always_comb begin
        n_cnt  = (r_motion ? '0 : r_cnt) + 1'b1;
        n_done = (n_cnt >= r_target) || (32'(n_cnt) >= 32'(MAX_TARGET));
    end

    // restoring division: quotient < 2^16, so the top bits seed the remainder
    always_comb begin
        for (int i = 0; i < sca_pkg::AXIS_N; i++) begin
            w_mag[i]   = r_sum[i][SUM_W-1] ? SUM_W'(-r_sum[i]) : SUM_W'(r_sum[i]);
            w_trial[i] = {r_rem[i], r_dq[i][AW-1]};
            w_ge[i]    = w_trial[i] >= {1'b0, r_cnt};
            n_rem[i]   = w_ge[i] ? REM_W'(w_trial[i] - {1'b0, r_cnt}) : REM_W'(w_trial[i]);
            n_dq[i]    = {r_dq[i][AW-2:0], w_ge[i]};
            n_mean[i]  = r_neg[i] ? sca_pkg::t_axis'(-n_dq[i]) : sca_pkg::t_axis'(n_dq[i]);
        end
    end

    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign o_stat.done     = r_done;
    assign o_stat.out_free = w_out_free;

    always_ff @(posedge i_clk) begin
        r_lim <= w_lim;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= sca_pkg::TARGET_RST;
            r_maxdev    <= sca_pkg::MAXDEV_RST;
            r_cnt       <= '0;
            r_done      <= 1'b0;
            r_motion    <= 1'b0;
            r_status    <= sca_pkg::STAT_ACCUM;
            r_restarted <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < sca_pkg::AXIS_N; i++) begin
                r_sum[i]  <= '0;
                r_min[i]  <= sca_pkg::MIN_RST;
                r_max[i]  <= sca_pkg::MAX_RST;
                r_mean[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sca_pkg::CFG_TARGET: r_target <= i_cfg_data;
                    sca_pkg::CFG_MAXDEV: r_maxdev <= i_cfg_data[sca_pkg::MDEV_W-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.take_clear) begin
                r_cnt       <= '0;
                r_done      <= 1'b0;
                r_status    <= sca_pkg::STAT_ACCUM;
                r_restarted <= 1'b0;
                for (int i = 0; i < sca_pkg::AXIS_N; i++) begin
                    r_sum[i]  <= '0;
                    r_min[i]  <= sca_pkg::MIN_RST;
                    r_max[i]  <= sca_pkg::MAX_RST;
                    r_mean[i] <= '0;
                end
            end

            if (i_cmd.take_ignore) begin
                r_status    <= sca_pkg::STAT_IGNORED;
                r_restarted <= 1'b0;
            end

            if (i_cmd.check) begin
                r_motion <= (r_cnt != '0) && w_any_over;
            end

            if (i_cmd.update) begin
                r_cnt       <= n_cnt;
                r_done      <= n_done;
                r_status    <= n_done ? sca_pkg::STAT_COMPLETE : sca_pkg::STAT_ACCUM;
                r_restarted <= r_motion;
                for (int i = 0; i < sca_pkg::AXIS_N; i++) begin
                    r_sum[i] <= (r_motion ? '0 : r_sum[i]) + SUM_W'(r_raw[i]);
                    if (r_motion || (r_raw[i] < r_min[i])) begin
                        r_min[i] <= r_raw[i];
                    end
                    if (r_motion || (r_raw[i] > r_max[i])) begin
                        r_max[i] <= r_raw[i];
                    end
                end
            end

            if (i_cmd.div_step && i_cmd.div_last) begin
                for (int i = 0; i < sca_pkg::AXIS_N; i++) begin
                    r_mean[i] <= n_mean[i];
                end
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_sample) begin
            for (int i = 0; i < sca_pkg::AXIS_N; i++) begin
                r_raw[i] <= w_in[i];
            end
        end
        if (i_cmd.div_init) begin
            for (int i = 0; i < sca_pkg::AXIS_N; i++) begin
                r_neg[i] <= r_sum[i][SUM_W-1];
                r_rem[i] <= REM_W'(w_mag[i] >> AW);
                r_dq[i]  <= w_mag[i][AW-1:0];
            end
        end else if (i_cmd.div_step) begin
            for (int i = 0; i < sca_pkg::AXIS_N; i++) begin
                r_rem[i] <= n_rem[i];
                r_dq[i]  <= n_dq[i];
            end
        end
        if (i_cmd.emit) begin
            r_o_status    <= r_status;
            r_o_restarted <= r_restarted;
            r_o_cnt       <= r_cnt;
            for (int i = 0; i < sca_pkg::AXIS_N; i++) begin
                r_o_mean[i] <= r_mean[i];
                r_o_min[i]  <= r_min[i];
                r_o_max[i]  <= r_max[i];
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_restarted    = r_o_restarted;
    assign o_sample_count = r_o_cnt;
    assign o_mean_x       = r_o_mean[0];
    assign o_mean_y       = r_o_mean[1];
    assign o_mean_z       = r_o_mean[2];
    assign o_min_x        = r_o_min[0];
    assign o_min_y        = r_o_min[1];
    assign o_min_z        = r_o_min[2];
    assign o_max_x        = r_o_max[0];
    assign o_max_y        = r_o_max[1];
    assign o_max_z        = r_o_max[2];

endmodule

/* hdl/sca_chk.sv */
// Port-level checker for the still capture accumulator, bound to the top.
// Depends on sca_pkg and still_capture_accumulator_unit.
`timescale 1ns / 1ps

module sca_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [sca_pkg::STAT_W-1:0]        o_status,
    input logic                              o_restarted,
    input logic [sca_pkg::CNT_W-1:0]         o_sample_count,
    input logic signed [sca_pkg::AXIS_W-1:0] o_mean_x,
    input logic signed [sca_pkg::AXIS_W-1:0] o_mean_y,
    input logic signed [sca_pkg::AXIS_W-1:0] o_mean_z,
    input logic signed [sca_pkg::AXIS_W-1:0] o_min_x,
    input logic signed [sca_pkg::AXIS_W-1:0] o_max_x
);

    // no result survives reset
    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // stalled transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_sample_count) && $stable(o_status)
            && $stable(o_mean_x))
        else $error("stalled result changed");

    // an empty capture reports zero means and the accumulating status
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_sample_count == '0) |->
            (o_mean_x == '0) && (o_mean_y == '0) && (o_mean_z == '0)
            && (o_status == sca_pkg::STAT_ACCUM) && !o_restarted
            && (o_min_x == sca_pkg::MIN_RST) && (o_max_x == sca_pkg::MAX_RST))
        else $error("empty capture reported wrongly");

    // restart only on an accumulating sample, which leaves a nonempty capture
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_restarted |->
            (o_status != sca_pkg::STAT_IGNORED) && (o_sample_count != '0))
        else $error("restart flag on wrong result");

    // completed or ignored results come from a nonempty capture
    a_done_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_status == sca_pkg::STAT_COMPLETE)
            || (o_status == sca_pkg::STAT_IGNORED)) |->
            (o_sample_count != '0) && (o_min_x <= o_max_x))
        else $error("done status with empty capture");

endmodule

bind still_capture_accumulator_unit sca_chk u_sca_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_restarted    (o_restarted),
    .o_sample_count (o_sample_count),
    .o_mean_x       (o_mean_x),
    .o_mean_y       (o_mean_y),
    .o_mean_z       (o_mean_z),
    .o_min_x        (o_min_x),
    .o_max_x        (o_max_x)
);
